FILE: hw/rtl/rgbhsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types, constants and the divider step for the RGB to HSV pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned AccW   = 2 * ChanW;
    localparam int unsigned DataW  = 3 * ChanW;
    localparam int unsigned DivStages      = 4;
    localparam int unsigned StepsPerStage  = ChanW / DivStages;

    localparam logic [ChanW-1:0] HueOffsetRed   = 8'd0;
    localparam logic [ChanW-1:0] HueOffsetGreen = 8'd85;
    localparam logic [ChanW-1:0] HueOffsetBlue  = 8'd171;
    localparam logic [5:0]       HueScale       = 6'd43;

    typedef struct packed {
        logic [ChanW-1:0] brightness;
        logic [ChanW-1:0] span;
        logic [AccW-1:0]  sat_acc;
        logic [AccW-1:0]  hue_acc;
        logic             neg;
        logic [ChanW-1:0] offset;
        logic             black;
        logic             gray;
    } work_t;

    // one restoring division step: upper half is the partial remainder,
    // lower half shifts out numerator bits and shifts in quotient bits
    function automatic logic [AccW-1:0] div_step(input logic [AccW-1:0] acc,
                                                 input logic [ChanW-1:0] den);
        logic [ChanW:0] top;
        logic [ChanW:0] diff;
        logic [AccW-1:0] res;
        top  = acc[AccW-1:ChanW-1];
        diff = top - {1'b0, den};
        if (top >= {1'b0, den}) begin
            res = {diff[ChanW-1:0], acc[ChanW-2:0], 1'b1};
        end else begin
            res = {top[ChanW-1:0], acc[ChanW-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/rgbhsv_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_prep
// First stage: channel max/min, hue sector, and both division numerators.
// ----------------------------------------------------------------------------
module rgbhsv_prep (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rgbhsv_pkg::ChanW-1:0]  red,
    input  logic [rgbhsv_pkg::ChanW-1:0]  green,
    input  logic [rgbhsv_pkg::ChanW-1:0]  blue,
    output logic                          out_valid,
    output rgbhsv_pkg::work_t             out_work,
    input  logic                          out_ready
);
    import rgbhsv_pkg::*;

    logic             valid_reg;
    work_t            work_reg;
    work_t            work_next;
    logic [ChanW-1:0] hi;
    logic [ChanW-1:0] lo;
    logic [ChanW-1:0] p;
    logic [ChanW-1:0] q;
    logic [ChanW-1:0] mag;
    logic [ChanW-1:0] span;
    logic [ChanW-1:0] offset;
    logic [13:0]      hue_num;

    always_comb begin
        lo = red;
        if (green < lo) begin
            lo = green;
        end
        if (blue < lo) begin
            lo = blue;
        end
        if (red >= green && red >= blue) begin
            hi     = red;
            p      = green;
            q      = blue;
            offset = HueOffsetRed;
        end else if (green >= blue) begin
            hi     = green;
            p      = blue;
            q      = red;
            offset = HueOffsetGreen;
        end else begin
            hi     = blue;
            p      = red;
            q      = green;
            offset = HueOffsetBlue;
        end
        span    = hi - lo;
        mag     = (p >= q) ? (p - q) : (q - p);
        hue_num = {8'd0, HueScale} * {6'd0, mag};

        work_next.brightness = hi;
        work_next.span       = span;
        work_next.sat_acc    = {span, {ChanW{1'b0}}} - {{ChanW{1'b0}}, span};
        work_next.hue_acc    = {2'b00, hue_num};
        work_next.neg        = (p < q);
        work_next.offset     = offset;
        work_next.black      = (hi == '0);
        work_next.gray       = (span == '0);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

endmodule

FILE: hw/rtl/rgbhsv_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_div_stage
// Divider pipeline stage: two quotient bits for saturation and hue each.
// ----------------------------------------------------------------------------
module rgbhsv_div_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rgbhsv_pkg::work_t in_work,
    output logic              out_valid,
    output rgbhsv_pkg::work_t out_work,
    input  logic              out_ready
);
    import rgbhsv_pkg::*;

    logic  valid_reg;
    work_t work_reg;
    work_t work_next;

    always_comb begin
        work_next = in_work;
        for (int i = 0; i < StepsPerStage; i++) begin
            work_next.sat_acc = div_step(work_next.sat_acc, in_work.brightness);
            work_next.hue_acc = div_step(work_next.hue_acc, in_work.span);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

endmodule

FILE: hw/rtl/rgbhsv_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_post
// Output stage: hue sign and sector offset, black and gray cases, output beat.
// ----------------------------------------------------------------------------
module rgbhsv_post (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rgbhsv_pkg::work_t            in_work,
    output logic                         out_valid,
    output logic [rgbhsv_pkg::DataW-1:0] out_data,
    input  logic                         out_ready
);
    import rgbhsv_pkg::*;

    logic             valid_reg;
    logic [DataW-1:0] data_reg;
    logic [DataW-1:0] data_next;
    logic [ChanW-1:0] quo;
    logic [ChanW-1:0] term;
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] sat;

    always_comb begin
        quo  = in_work.hue_acc[ChanW-1:0];
        term = in_work.neg ? (~quo + 8'd1) : quo;
        hue  = (in_work.black || in_work.gray) ? '0 : in_work.offset + term;
        sat  = in_work.black ? '0 : in_work.sat_acc[ChanW-1:0];
        data_next = {in_work.brightness, sat, hue};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: hw/rtl/rgb_to_hsv_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// Converts a stream of 8-bit RGB pixels into 8-bit HSV triples.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one pixel per beat, tdata = red, green, blue from bit 0 up
//   m_ channel: one result per beat, tdata = hue, saturation, brightness
//   throughput: one pixel per cycle, sustained while the receiver keeps m_tready high
//   stages: max/min and numerators, four divider stages of two quotient
//     bits each (saturation and hue divided side by side), output stage
//   the divider chain sets the depth; each stage is one 9-bit
//     compare-subtract pair per quotient bit
//   every stage holds its own valid bit and takes a new beat whenever it
//     is empty or its successor moves, so bubbles close up
//   receiver stall: results wait in their stages, s_tready falls once the
//     pipe is full, nothing is lost or repeated
//   reset: clears all valid bits, the pipe is empty, no output beat
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rgbhsv_pkg::DataW-1:0] s_tdata,  // red, green, blue
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rgbhsv_pkg::DataW-1:0] m_tdata   // hue, saturation, brightness
);
    import rgbhsv_pkg::*;

    logic  valid_c [DivStages+1];
    logic  ready_c [DivStages+1];
    work_t work_c  [DivStages+1];

    rgbhsv_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[ChanW-1:0]),
        .green     (s_tdata[2*ChanW-1:ChanW]),
        .blue      (s_tdata[3*ChanW-1:2*ChanW]),
        .out_valid (valid_c[0]),
        .out_work  (work_c[0]),
        .out_ready (ready_c[0])
    );

    for (genvar i = 0; i < DivStages; i++) begin : g_div
        rgbhsv_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_work   (work_c[i]),
            .out_valid (valid_c[i+1]),
            .out_work  (work_c[i+1]),
            .out_ready (ready_c[i+1])
        );
    end

    rgbhsv_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_c[DivStages]),
        .in_ready  (ready_c[DivStages]),
        .in_work   (work_c[DivStages]),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_ready (m_tready)
    );

endmodule

FILE: tb/tb_rgb_to_hsv_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter_unit
// Streams RGB pixels into the converter and checks every HSV beat against a
// behavioural prediction in arrival order. A directed set covers black, gray,
// pure and tied channels and negative hue terms, then mixed random pixels
// follow under random idling on both sides, one long receiver stall and
// sender pauses that drain the pipe.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter_unit;
    import rgbhsv_pkg::*;

    localparam int unsigned HueBaseRed   = 0;
    localparam int unsigned HueBaseGreen = 85;
    localparam int unsigned HueBaseBlue  = 171;
    localparam int unsigned HueGain      = 43;
    localparam int unsigned SatFull      = 255;

    localparam int unsigned RandomPixels = 1925;
    localparam int unsigned DrainEvery   = 480;
    localparam int unsigned IdlePct      = 22;
    localparam int unsigned HoldAt       = 400;
    localparam int unsigned HoldCycles   = 64;
    localparam int unsigned CalmFrom     = 1000;
    localparam int unsigned CalmTo       = 1300;
    localparam int unsigned StallLimit   = 2000;
    localparam int unsigned TailCycles   = 20;

    typedef struct {
        logic [DataW-1:0] pix;
        bit               drain_first;
    } pixel_item_t;

    typedef struct packed {
        logic [ChanW-1:0] brightness;
        logic [ChanW-1:0] saturation;
        logic [ChanW-1:0] hue;
    } hsv_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [DataW-1:0] s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [DataW-1:0] m_tdata;

    pixel_item_t pend_q[$];
    hsv_t        hsv_q[$];
    bit          pix_taken = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned pix_cnt   = 0;
    int unsigned stall_cnt = 0;
    int unsigned err_cnt   = 0;
    logic        calm;

    assign calm = (pix_cnt >= CalmFrom) && (pix_cnt < CalmTo);

    rgb_to_hsv_converter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic hsv_t hsv_of(input logic [DataW-1:0] pix);
        int unsigned r, g, b, hi, lo, span, p, q, quo;
        logic [ChanW-1:0] base;
        hsv_t res;
        r = 32'(pix[ChanW-1:0]);
        g = 32'(pix[2*ChanW-1:ChanW]);
        b = 32'(pix[3*ChanW-1:2*ChanW]);
        hi = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        lo = r;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        span = hi - lo;
        res = '0;
        res.brightness = hi[ChanW-1:0];
        // black and gray pixels leave hue and saturation at zero
        if (hi == 0 || span == 0) begin
            return res;
        end
        quo = (SatFull * span) / hi;
        res.saturation = quo[ChanW-1:0];
        // red wins ties, then green
        if (r == hi) begin
            base = HueBaseRed[ChanW-1:0];
            p = g;
            q = b;
        end else if (g == hi) begin
            base = HueBaseGreen[ChanW-1:0];
            p = b;
            q = r;
        end else begin
            base = HueBaseBlue[ChanW-1:0];
            p = r;
            q = g;
        end
        if (p >= q) begin
            quo = (HueGain * (p - q)) / span;
            res.hue = base + quo[ChanW-1:0];
        end else begin
            quo = (HueGain * (q - p)) / span;
            res.hue = base - quo[ChanW-1:0];
        end
        return res;
    endfunction

    task automatic check_hsv(input logic [DataW-1:0] got);
        hsv_t want;
        hsv_t seen;
        if (hsv_q.size() == 0) begin
            $error("result beat %h with no pixel outstanding", got);
            err_cnt++;
            return;
        end
        want = hsv_q.pop_front();
        seen = got;
        if (seen.hue !== want.hue) begin
            $error("hue: expected %0d, got %0d", want.hue, seen.hue);
            err_cnt++;
        end
        if (seen.saturation !== want.saturation) begin
            $error("saturation: expected %0d, got %0d", want.saturation, seen.saturation);
            err_cnt++;
        end
        if (seen.brightness !== want.brightness) begin
            $error("brightness: expected %0d, got %0d", want.brightness, seen.brightness);
            err_cnt++;
        end
    endtask

    // pixel driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || pix_taken)) begin
            if (pend_q.size() != 0 && !(pend_q[0].drain_first && hsv_q.size() != 0)
                && (calm || $urandom_range(99) >= IdlePct)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pend_q[0].pix;
                void'(pend_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, one long hold-off once the stream is under way
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left != 0) begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && pix_cnt >= HoldAt) begin
                m_tready  <= 1'b0;
                hold_left <= HoldCycles;
                hold_done <= 1'b1;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= IdlePct);
            end
        end
    end

    // beat monitor and watchdog
    always @(posedge aclk) begin
        pix_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                hsv_q.push_back(hsv_of(s_tdata));
                pix_cnt++;
            end
            if (m_tvalid === 1'b1 && m_tready) begin
                check_hsv(m_tdata);
            end
            if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready)) begin
                stall_cnt = 0;
            end else begin
                stall_cnt++;
            end
            if (stall_cnt >= StallLimit) begin
                $display("tb_rgb_to_hsv_converter_unit: done, errors");
                $finish;
            end
        end
    end

    initial begin
        pixel_item_t item;
        logic [ChanW-1:0] r, g, b, lvl;
        // each entry is blue, green, red
        logic [DataW-1:0] directed[$] = '{
            {8'd0,   8'd0,   8'd0},   {8'd255, 8'd255, 8'd255},
            {8'd128, 8'd128, 8'd128}, {8'd1,   8'd1,   8'd1},
            {8'd0,   8'd0,   8'd255}, {8'd0,   8'd255, 8'd0},
            {8'd255, 8'd0,   8'd0},   {8'd0,   8'd100, 8'd255},
            {8'd100, 8'd0,   8'd255}, {8'd100, 8'd255, 8'd0},
            {8'd0,   8'd255, 8'd100}, {8'd255, 8'd0,   8'd100},
            {8'd255, 8'd100, 8'd0},   {8'd10,  8'd200, 8'd200},
            {8'd200, 8'd10,  8'd200}, {8'd200, 8'd200, 8'd10},
            {8'd0,   8'd0,   8'd1},   {8'd0,   8'd1,   8'd0},
            {8'd1,   8'd0,   8'd0},   {8'd254, 8'd254, 8'd255},
            {8'd253, 8'd255, 8'd254}, {8'd255, 8'd0,   8'd255}
        };

        foreach (directed[i]) begin
            item.pix = directed[i];
            item.drain_first = 1'b0;
            pend_q.push_back(item);
        end
        for (int unsigned i = 0; i < RandomPixels; i++) begin
            lvl = 8'($urandom);
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            case ($urandom_range(9))
                0: begin
                    r = lvl;
                    g = lvl;
                    b = lvl;
                end
                1, 2: begin
                    case ($urandom_range(2))
                        0: begin r = lvl; g = lvl; end
                        1: begin r = lvl; b = lvl; end
                        default: begin g = lvl; b = lvl; end
                    endcase
                end
                3: begin
                    r = lvl ^ 8'($urandom_range(3));
                    g = lvl ^ 8'($urandom_range(3));
                    b = lvl ^ 8'($urandom_range(3));
                end
                default: ;
            endcase
            item.pix = {b, g, r};
            item.drain_first = (i == 0) || (i % DrainEvery == DrainEvery - 1);
            pend_q.push_back(item);
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (pend_q.size() == 0 && !s_tvalid);
        wait (hsv_q.size() == 0);
        repeat (TailCycles) @(posedge aclk);

        if (err_cnt == 0 && hsv_q.size() == 0) begin
            $display("tb_rgb_to_hsv_converter_unit: done, clean");
        end else begin
            $display("tb_rgb_to_hsv_converter_unit: done, errors");
        end
        $finish;
    end

endmodule
